FILE: design/tlq_pkg.sv
// Shared constants and types for the two-way light queue scheduler.
package tlq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TIME_WIDTH  = 16;
    localparam int LEN_WIDTH   = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 8;
    localparam int PERIOD_WIDTH   = 8;
    localparam int STAT_WIDTH     = 32;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_LEFT_PERIOD  = 2'd0,
        CFG_RIGHT_PERIOD = 2'd1,
        CFG_FIRST_SIDE   = 2'd2
    } t_cfg_idx;

    localparam logic [PERIOD_WIDTH-1:0] LEFT_PERIOD_RST  = 8'd3;
    localparam logic [PERIOD_WIDTH-1:0] RIGHT_PERIOD_RST = 8'd4;
    localparam logic                    FIRST_SIDE_RST   = 1'b0;

    localparam int SIDE_LEFT  = 0;
    localparam int SIDE_RIGHT = 1;

endpackage

FILE: design/tlq_in_if.sv
// Input channel: one tick with the arrival bits of both approaches.
interface tlq_in_if;
    logic valid;
    logic ready;
    logic arrive_left;
    logic arrive_right;

    modport source (output valid, output arrive_left, output arrive_right, input ready);
    modport sink   (input valid, input arrive_left, input arrive_right, output ready);
endinterface

FILE: design/tlq_out_if.sv
// Result channel: light state, service and statistics for one tick.
interface tlq_out_if #(
    parameter int TIME_W = tlq_pkg::TIME_WIDTH,
    parameter int LEN_W  = tlq_pkg::LEN_WIDTH
);
    logic                            valid;
    logic                            ready;
    logic                            green_is_left;
    logic                            car_served;
    logic [TIME_W-1:0]               wait_time;
    logic [LEN_W-1:0]                left_queue_len;
    logic [LEN_W-1:0]                right_queue_len;
    logic [TIME_W-1:0]               peak_wait_left;
    logic [TIME_W-1:0]               peak_wait_right;
    logic [tlq_pkg::STAT_WIDTH-1:0]  served_left_total;
    logic [tlq_pkg::STAT_WIDTH-1:0]  served_right_total;
    logic [tlq_pkg::STAT_WIDTH-1:0]  wait_sum_left;
    logic [tlq_pkg::STAT_WIDTH-1:0]  wait_sum_right;
    logic                            arrival_dropped;

    modport source (
        output valid, input ready,
        output green_is_left, output car_served, output wait_time,
        output left_queue_len, output right_queue_len,
        output peak_wait_left, output peak_wait_right,
        output served_left_total, output served_right_total,
        output wait_sum_left, output wait_sum_right, output arrival_dropped
    );
    modport sink (
        input valid, output ready,
        input green_is_left, input car_served, input wait_time,
        input left_queue_len, input right_queue_len,
        input peak_wait_left, input peak_wait_right,
        input served_left_total, input served_right_total,
        input wait_sum_left, input wait_sum_right, input arrival_dropped
    );
endinterface

FILE: design/two_way_light_queue_scheduler.sv
// Top level of the two-way light queue scheduler.
//
//   Channel   Dir  Carries
//   i_arr     in   arrive_left, arrive_right (one tick per item)
//   o_res     out  green side, served car and wait, queue lengths, statistics
//   i_cfg_*   in   left_period, right_period, first_green_side writes
//
// One tick is accepted per clock; its result appears in the output register
// on the next cycle. The head stamp of each queue is prefetched from its RAM
// every cycle, with a bypass for an entry written at the new head address.
// Reset is synchronous; the queue RAMs are not cleared. A stalled result
// blocks input only while the output register is full and not being taken.
module two_way_light_queue_scheduler #(
    parameter int QUEUE_DEPTH = tlq_pkg::QUEUE_DEPTH,
    parameter int TIME_WIDTH  = tlq_pkg::TIME_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tlq_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [tlq_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    tlq_in_if.sink                             i_arr,
    tlq_out_if.source                          o_res
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PER_W = tlq_pkg::PERIOD_WIDTH;
    localparam int STW   = tlq_pkg::STAT_WIDTH;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(QUEUE_DEPTH);

    // Configuration.
    logic [PER_W-1:0] r_left_period, r_right_period;

    // Control state.
    logic [TIME_WIDTH-1:0] r_tick, n_tick;
    logic                  r_phase_right, n_phase_right;
    logic [PER_W-1:0]      r_phase_ticks, n_phase_ticks;
    logic                  r_started;
    logic [PTR_W-1:0]      r_head [2];
    logic [PTR_W-1:0]      n_head [2];
    logic [PTR_W-1:0]      r_tail [2];
    logic [PTR_W-1:0]      n_tail [2];
    logic [LEN_W-1:0]      r_len [2];
    logic [LEN_W-1:0]      n_len [2];
    logic [TIME_WIDTH-1:0] r_max_wait [2];
    logic [TIME_WIDTH-1:0] n_max_wait [2];
    logic [STW-1:0]        r_served [2];
    logic [STW-1:0]        n_served [2];
    logic [STW-1:0]        r_wsum [2];
    logic [STW-1:0]        n_wsum [2];

    // Head prefetch bypass.
    logic                  r_byp_vld [2];
    logic                  n_byp_vld [2];
    logic [TIME_WIDTH-1:0] r_byp_data [2];
    logic [TIME_WIDTH-1:0] w_rdata [2];
    logic [TIME_WIDTH-1:0] w_head_stamp [2];
    logic                  w_we [2];
    logic                  w_arrive [2];

    // Result register.
    logic                  r_out_vld;
    logic                  r_o_green_left, n_o_green_left;
    logic                  r_o_served, n_o_served;
    logic [TIME_WIDTH-1:0] r_o_wait, n_o_wait;
    logic                  r_o_drop, n_o_drop;

    logic                  w_accept;
    logic                  w_side;
    logic [TIME_WIDTH-1:0] w_stamp;
    logic [STW:0]          w_sum_ext;
    logic [PER_W-1:0]      w_period;

    assign i_arr.ready = !r_out_vld || o_res.ready;
    assign w_accept    = i_arr.valid && i_arr.ready;
    assign w_arrive[tlq_pkg::SIDE_LEFT]  = i_arr.arrive_left;
    assign w_arrive[tlq_pkg::SIDE_RIGHT] = i_arr.arrive_right;
    assign w_side = r_phase_right;

    always_comb begin
        n_tick        = r_tick;
        n_phase_right = r_phase_right;
        n_phase_ticks = r_phase_ticks;
        n_o_green_left = !w_side;
        n_o_served    = 1'b0;
        n_o_wait      = '0;
        n_o_drop      = 1'b0;
        w_stamp       = '0;
        w_sum_ext     = '0;
        w_period      = w_side ? r_right_period : r_left_period;
        for (int s = 0; s < 2; s++) begin
            n_head[s]     = r_head[s];
            n_tail[s]     = r_tail[s];
            n_len[s]      = r_len[s];
            n_max_wait[s] = r_max_wait[s];
            n_served[s]   = r_served[s];
            n_wsum[s]     = r_wsum[s];
            w_we[s]       = 1'b0;
            w_head_stamp[s] = r_byp_vld[s] ? r_byp_data[s] : w_rdata[s];
        end

        if (w_accept) begin
            n_tick = r_tick + 1'b1;

            // Arrivals go in before the departure.
            for (int s = 0; s < 2; s++) begin
                if (w_arrive[s]) begin
                    if (r_len[s] == LEN_FULL) begin
                        n_o_drop = 1'b1;
                    end else begin
                        w_we[s]   = 1'b1;
                        n_tail[s] = (r_tail[s] == PTR_LAST) ? '0 : r_tail[s] + 1'b1;
                        n_len[s]  = r_len[s] + 1'b1;
                    end
                end
            end

            if (n_len[w_side] != '0) begin
                // A car that found its queue empty is the one just stamped.
                w_stamp = (r_len[w_side] == '0) ? n_tick : w_head_stamp[w_side];
                n_o_served = 1'b1;
                n_o_wait   = n_tick - w_stamp;
                n_head[w_side] = (r_head[w_side] == PTR_LAST) ? '0 : r_head[w_side] + 1'b1;
                n_len[w_side]  = n_len[w_side] - 1'b1;
                if (n_o_wait > r_max_wait[w_side]) begin
                    n_max_wait[w_side] = n_o_wait;
                end
                if (r_served[w_side] != '1) begin
                    n_served[w_side] = r_served[w_side] + 1'b1;
                end
                w_sum_ext = {1'b0, r_wsum[w_side]} + (STW + 1)'(n_o_wait);
                n_wsum[w_side] = w_sum_ext[STW] ? '1 : w_sum_ext[STW-1:0];
            end

            if (w_period == '0) begin
                w_period = PER_W'(1);
            end
            n_phase_ticks = r_phase_ticks + 1'b1;
            if (n_phase_ticks >= w_period) begin
                n_phase_ticks = '0;
                n_phase_right = !w_side;
            end
        end else if (i_cfg_we && (i_cfg_idx == tlq_pkg::CFG_FIRST_SIDE) && !r_started) begin
            n_phase_right = i_cfg_data[0];
        end

        // An entry written at the address being prefetched is forwarded.
        for (int s = 0; s < 2; s++) begin
            n_byp_vld[s] = w_we[s] && (r_tail[s] == n_head[s]);
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_queue
        tlq_ram #(
            .WIDTH (TIME_WIDTH),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[g]),
            .i_waddr (r_tail[g]),
            .i_wdata (n_tick),
            .i_raddr (n_head[g]),
            .o_rdata (w_rdata[g])
        );
    end

    // The start side only acts on the phase register before the first tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_period  <= tlq_pkg::LEFT_PERIOD_RST;
            r_right_period <= tlq_pkg::RIGHT_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tlq_pkg::CFG_LEFT_PERIOD:  r_left_period  <= i_cfg_data[PER_W-1:0];
                tlq_pkg::CFG_RIGHT_PERIOD: r_right_period <= i_cfg_data[PER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick        <= '0;
            r_phase_right <= tlq_pkg::FIRST_SIDE_RST;
            r_phase_ticks <= '0;
            r_started     <= 1'b0;
            r_out_vld     <= 1'b0;
            for (int s = 0; s < 2; s++) begin
                r_head[s]     <= '0;
                r_tail[s]     <= '0;
                r_len[s]      <= '0;
                r_max_wait[s] <= '0;
                r_served[s]   <= '0;
                r_wsum[s]     <= '0;
                r_byp_vld[s]  <= 1'b0;
            end
        end else begin
            r_tick        <= n_tick;
            r_phase_right <= n_phase_right;
            r_phase_ticks <= n_phase_ticks;
            if (w_accept) begin
                r_started <= 1'b1;
            end
            if (w_accept) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            for (int s = 0; s < 2; s++) begin
                r_head[s]     <= n_head[s];
                r_tail[s]     <= n_tail[s];
                r_len[s]      <= n_len[s];
                r_max_wait[s] <= n_max_wait[s];
                r_served[s]   <= n_served[s];
                r_wsum[s]     <= n_wsum[s];
                r_byp_vld[s]  <= n_byp_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < 2; s++) begin
            if (w_we[s]) begin
                r_byp_data[s] <= n_tick;
            end
        end
        if (w_accept) begin
            r_o_green_left <= n_o_green_left;
            r_o_served     <= n_o_served;
            r_o_wait       <= n_o_wait;
            r_o_drop       <= n_o_drop;
        end
    end

    // Queue lengths and statistics are read straight from state, which only
    // moves when a new item is accepted into the output register.
    assign o_res.valid              = r_out_vld;
    assign o_res.green_is_left      = r_o_green_left;
    assign o_res.car_served         = r_o_served;
    assign o_res.wait_time          = r_o_wait;
    assign o_res.left_queue_len     = r_len[tlq_pkg::SIDE_LEFT];
    assign o_res.right_queue_len    = r_len[tlq_pkg::SIDE_RIGHT];
    assign o_res.peak_wait_left     = r_max_wait[tlq_pkg::SIDE_LEFT];
    assign o_res.peak_wait_right    = r_max_wait[tlq_pkg::SIDE_RIGHT];
    assign o_res.served_left_total  = r_served[tlq_pkg::SIDE_LEFT];
    assign o_res.served_right_total = r_served[tlq_pkg::SIDE_RIGHT];
    assign o_res.wait_sum_left      = r_wsum[tlq_pkg::SIDE_LEFT];
    assign o_res.wait_sum_right     = r_wsum[tlq_pkg::SIDE_RIGHT];
    assign o_res.arrival_dropped    = r_o_drop;
endmodule

FILE: design/tlq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlq_ram #(
    parameter int WIDTH = tlq_pkg::TIME_WIDTH,
    parameter int DEPTH = tlq_pkg::QUEUE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
